[hw/rtl/ebm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_pkg
// shared types, sizes and register codes of the eight-way border mask unit
// ----------------------------------------------------------------------------
package ebm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = COL_BITS + 1;
    localparam int CFG_W_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int VALUE_BITS  = 16;
    localparam int MASK_BITS   = 8;
    localparam int LINE_BITS   = 2 * VALUE_BITS;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // input kind codes
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // mask bit positions
    localparam int BIT_N  = 0;
    localparam int BIT_NW = 1;
    localparam int BIT_W  = 2;
    localparam int BIT_SW = 3;
    localparam int BIT_S  = 4;
    localparam int BIT_SE = 5;
    localparam int BIT_E  = 6;
    localparam int BIT_NE = 7;

    // one item on its way from the counter stage to the window stage
    typedef struct packed {
        logic                  pixel;
        logic                  emit;
        logic [COL_BITS-1:0]   col;
        logic [VALUE_BITS-1:0] value;
        logic                  north;
        logic                  south;
        logic                  west;
        logic                  east;
        logic                  end_of_row;
        logic                  end_of_image;
    } ebm_item_t;

    function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [CFG_W_BITS-1:0] raw);
        logic [WIDTH_BITS-1:0] res;
        if (raw < CFG_W_BITS'(2))
            res = WIDTH_BITS'(2);
        else if ({1'b0, raw} > (CFG_W_BITS + 1)'(MAX_WIDTH))
            res = WIDTH_BITS'(MAX_WIDTH);
        else
            res = WIDTH_BITS'(raw);
        return res;
    endfunction

    function automatic logic [HEIGHT_BITS-1:0] clamp_height(input logic [HEIGHT_BITS-1:0] raw);
        logic [HEIGHT_BITS-1:0] res;
        if (raw < HEIGHT_BITS'(2))
            res = HEIGHT_BITS'(2);
        else
            res = raw;
        return res;
    endfunction

endpackage

[hw/rtl/ebm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ebm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ebm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_ctrl
// configuration registers, input and output position counters, line store read
// ----------------------------------------------------------------------------
module ebm_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic                              wr_index,
    input  logic [ebm_pkg::HEIGHT_BITS-1:0]   wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ebm_pkg::VALUE_BITS-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              b_take,
    output logic                              b_valid,
    output ebm_pkg::ebm_item_t                b_item,
    output logic                              rd_en,
    output logic [ebm_pkg::COL_BITS-1:0]      rd_addr
);

    localparam int CB = ebm_pkg::COL_BITS;
    localparam int WB = ebm_pkg::WIDTH_BITS;
    localparam int HB = ebm_pkg::HEIGHT_BITS;

    logic [ebm_pkg::CFG_W_BITS-1:0] width_cfg_reg, width_cfg_next;
    logic [HB-1:0]                  height_cfg_reg, height_cfg_next;
    logic [CB-1:0]                  in_col_reg, in_col_next;
    logic [HB-1:0]                  in_row_reg, in_row_next;
    logic [CB-1:0]                  out_col_reg, out_col_next;
    logic [HB-1:0]                  out_row_reg, out_row_next;
    logic                           b_valid_reg, b_valid_next;
    ebm_pkg::ebm_item_t             b_item_reg, b_item_next;

    logic [WB-1:0]  w_eff;
    logic [HB-1:0]  h_eff;
    logic           accept;
    logic           draining;
    logic           pixel;
    logic           active;
    logic [CB-1:0]  col;
    logic [WB-1:0]  col_inc;
    logic           emit;
    logic [HB-1:0]  ro;
    logic [CB-1:0]  co;
    logic [WB-1:0]  co_inc;
    logic [HB:0]    ro_inc;
    logic           last_col;
    logic           last_row;

    assign w_eff  = ebm_pkg::clamp_width(width_cfg_reg);
    assign h_eff  = ebm_pkg::clamp_height(height_cfg_reg);
    assign s_tready = !b_valid_reg || b_take;
    assign accept = s_tvalid && s_tready;

    assign draining = in_row_reg >= h_eff;
    assign pixel    = (s_tuser == ebm_pkg::KIND_PIXEL) && !draining;
    assign active   = pixel || draining;
    assign col      = ({1'b0, in_col_reg} >= w_eff) ? '0 : in_col_reg;
    assign col_inc  = {1'b0, col} + WB'(1);
    // first result once one row plus one cell is in
    assign emit     = draining || (in_row_reg >= HB'(2))
                      || ((in_row_reg == HB'(1)) && (col != '0));

    assign ro       = (out_row_reg >= h_eff) ? h_eff - HB'(1) : out_row_reg;
    assign co       = ({1'b0, out_col_reg} >= w_eff) ? CB'(w_eff - WB'(1)) : out_col_reg;
    assign co_inc   = {1'b0, co} + WB'(1);
    assign ro_inc   = {1'b0, ro} + (HB + 1)'(1);
    assign last_col = co_inc == w_eff;
    assign last_row = ro_inc == {1'b0, h_eff};

    assign rd_en   = accept && active;
    assign rd_addr = col;

    always_comb
    begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        b_valid_next    = b_valid_reg;
        b_item_next     = b_item_reg;

        if (b_take)
        begin
            b_valid_next = 1'b0;
        end

        if (accept && active)
        begin
            b_valid_next             = 1'b1;
            b_item_next.pixel        = pixel;
            b_item_next.emit         = emit;
            b_item_next.col          = col;
            b_item_next.value        = pixel ? s_tdata : '0;
            b_item_next.north        = ro != '0;
            b_item_next.south        = !last_row;
            b_item_next.west         = co != '0;
            b_item_next.east         = !last_col;
            b_item_next.end_of_row   = last_col;
            b_item_next.end_of_image = last_col && last_row;

            if (col_inc >= w_eff)
            begin
                in_col_next = '0;
                if (!draining)
                begin
                    in_row_next = in_row_reg + HB'(1);
                end
            end
            else
            begin
                in_col_next = CB'(col_inc);
            end

            if (emit)
            begin
                if (last_col && last_row)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (last_col)
                begin
                    out_col_next = '0;
                    out_row_next = HB'(ro_inc);
                end
                else
                begin
                    out_col_next = CB'(co_inc);
                    out_row_next = ro;
                end
            end
        end

        if (wr_en)
        begin
            unique case (wr_index)
                ebm_pkg::REG_WIDTH:  width_cfg_next  = wr_data[ebm_pkg::CFG_W_BITS-1:0];
                ebm_pkg::REG_HEIGHT: height_cfg_next = wr_data;
                default:             width_cfg_next  = width_cfg_reg;
            endcase
            // a register write restarts the image
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= ebm_pkg::CFG_W_BITS'(2);
            height_cfg_reg <= HB'(2);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            b_valid_reg    <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_item_reg <= b_item_next;
    end

    assign b_valid = b_valid_reg;
    assign b_item  = b_item_reg;

endmodule

[hw/rtl/ebm_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebm_window
// line store write-back, 3x3 window shift, neighbour compare, output register
// ----------------------------------------------------------------------------
module ebm_window (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             b_valid,
    input  ebm_pkg::ebm_item_t               b_item,
    output logic                             b_take,
    input  logic [ebm_pkg::LINE_BITS-1:0]    rd_data,
    output logic                             wr_en,
    output logic [ebm_pkg::COL_BITS-1:0]     wr_addr,
    output logic [ebm_pkg::LINE_BITS-1:0]    wr_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ebm_pkg::MASK_BITS-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);

    localparam int VB = ebm_pkg::VALUE_BITS;

    logic [VB-1:0]                 win_reg  [9];
    logic [VB-1:0]                 win_next [9];
    logic                          out_valid_reg, out_valid_next;
    logic [ebm_pkg::MASK_BITS-1:0] mask_reg, mask_next;
    logic                          eor_reg, eoi_reg;
    logic [VB-1:0]                 top;
    logic [VB-1:0]                 mid;
    logic [VB-1:0]                 c;
    logic                          step;

    // line entry holds the row two above in the upper half, one above in the lower
    assign top = rd_data[ebm_pkg::LINE_BITS-1:VB];
    assign mid = rd_data[VB-1:0];

    assign b_take = b_valid && (!out_valid_reg || m_tready);
    assign step   = b_take;

    assign wr_en   = step && b_item.pixel;
    assign wr_addr = b_item.col;
    assign wr_data = {mid, b_item.value};

    // shift one column west, new column enters at east
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = b_item.value;
    end

    assign c = win_next[4];

    always_comb
    begin
        mask_next = '1;
        if (b_item.north && win_next[1] == c)
            mask_next[ebm_pkg::BIT_N] = 1'b0;
        if (b_item.north && b_item.west && win_next[0] == c)
            mask_next[ebm_pkg::BIT_NW] = 1'b0;
        if (b_item.west && win_next[3] == c)
            mask_next[ebm_pkg::BIT_W] = 1'b0;
        if (b_item.south && b_item.west && win_next[6] == c)
            mask_next[ebm_pkg::BIT_SW] = 1'b0;
        if (b_item.south && win_next[7] == c)
            mask_next[ebm_pkg::BIT_S] = 1'b0;
        if (b_item.south && b_item.east && win_next[8] == c)
            mask_next[ebm_pkg::BIT_SE] = 1'b0;
        if (b_item.east && win_next[5] == c)
            mask_next[ebm_pkg::BIT_E] = 1'b0;
        if (b_item.north && b_item.east && win_next[2] == c)
            mask_next[ebm_pkg::BIT_NE] = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (step && b_item.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && b_item.emit)
        begin
            mask_reg <= mask_next;
            eor_reg  <= b_item.end_of_row;
            eoi_reg  <= b_item.end_of_image;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mask_reg;
    assign m_tlast  = eor_reg;
    assign m_tuser  = eoi_reg;

endmodule

[hw/rtl/eight_way_border_mask_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_way_border_mask_unit
// streaming 3x3 eight-neighbour border mask over a raster-order label image
// ----------------------------------------------------------------------------
// Takes one label per clock in raster order while m_tready is high and
// returns for every cell an 8-bit mask (N, NW, W, SW, S, SE, E, NE from bit
// 0 up) whose bits are set where the neighbour differs or lies outside the
// image. The two line stores share one 1024 x 32 ram whose entry for a column
// is read when an item is accepted and written back when the window stage
// takes it, so the ram's single read and single write port set the pace. A
// result enters the output register as its completing item is taken and lags
// its cell by one row plus one cell; after the last pixel, image_width + 1
// drain items (tuser high) flush them out. A stall on the master side holds
// the pipeline and pulls s_tready low only once the output register and the
// window stage are both full. Writing either register restarts the image.
module eight_way_border_mask_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic                               wr_index,
    input  logic [ebm_pkg::HEIGHT_BITS-1:0]    wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ebm_pkg::VALUE_BITS-1:0]     s_tdata,   // pixel_value
    input  logic                               s_tuser,   // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ebm_pkg::MASK_BITS-1:0]      m_tdata,   // border_mask
    output logic                               m_tlast,
    output logic                               m_tuser    // end_of_image
);

    logic                              b_valid;
    logic                              b_take;
    ebm_pkg::ebm_item_t                b_item;
    logic                              rd_en;
    logic [ebm_pkg::COL_BITS-1:0]      rd_addr;
    logic [ebm_pkg::LINE_BITS-1:0]     rd_data;
    logic                              line_wr_en;
    logic [ebm_pkg::COL_BITS-1:0]      line_wr_addr;
    logic [ebm_pkg::LINE_BITS-1:0]     line_wr_data;

    ebm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .b_take   (b_take),
        .b_valid  (b_valid),
        .b_item   (b_item),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    ebm_ram #(
        .WIDTH (ebm_pkg::LINE_BITS),
        .DEPTH (ebm_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ebm_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .b_valid  (b_valid),
        .b_item   (b_item),
        .b_take   (b_take),
        .rd_data  (rd_data),
        .wr_en    (line_wr_en),
        .wr_addr  (line_wr_addr),
        .wr_data  (line_wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
